// ----- src/jgpds_pkg.sv -----
// Shared types, constants and the distance check for the jittered-grid
// Poisson-disk sampler. No dependencies.
`default_nettype none

package jgpds_pkg;

   // Storage and precision
   localparam int MAX_COLS  = 1024;
   localparam int FRAC_BITS = 16;
   localparam int TRY_BITS  = 6;

   // Field and register widths
   localparam int CNT_BITS    = 10;
   localparam int CNT_LIMIT   = 1024;
   localparam int DIM_BITS    = 11;
   localparam int TRIES_BITS  = 6;
   localparam int IN_BITS     = 16;
   localparam int INDEX_BITS  = 20;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 11;

   // Derived sizes
   localparam int COL_LIMIT   = (MAX_COLS < CNT_LIMIT) ? MAX_COLS : CNT_LIMIT;
   localparam int LB_IDX_BITS = $clog2(COL_LIMIT);
   localparam int TRY_MAX     = (1 << TRY_BITS) - 1;
   localparam int TRY_CMP_BITS = ((TRY_BITS > TRIES_BITS) ? TRY_BITS : TRIES_BITS) + 1;
   localparam int DIFF_BITS   = FRAC_BITS + 2;
   localparam int SQ_BITS     = 2 * DIFF_BITS;
   localparam int DIST_BITS   = SQ_BITS + 1;

   localparam logic [DIFF_BITS-1:0] FRAC_ONE = DIFF_BITS'(1) << FRAC_BITS;
   localparam logic [DIST_BITS-1:0] DIST_ONE = DIST_BITS'(1) << (2 * FRAC_BITS);

   // Configuration register indexes
   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_NUM_ROWS  = 2'd0,
      CSR_NUM_COLS  = 2'd1,
      CSR_MAX_TRIES = 2'd2
   } csr_index_type;

   // Stored sample: valid bit, row offset, column offset
   typedef struct packed {
      logic                 valid;
      logic [FRAC_BITS-1:0] u;
      logic [FRAC_BITS-1:0] v;
   } sample_type;

   // Line buffer write request
   typedef struct packed {
      logic                   en;
      logic [LB_IDX_BITS-1:0] idx;
      sample_type             data;
   } lb_write_type;

   // True when trial (u,v) lies closer than one cell to sample s, whose cell
   // sits drow rows and dcol columns toward lower indices.
   function automatic logic too_close(sample_type s, logic [FRAC_BITS-1:0] u,
                                      logic [FRAC_BITS-1:0] v, logic drow,
                                      logic dcol);
      logic [DIFF_BITS-1:0]        du;
      logic [DIFF_BITS-1:0]        dv;
      logic signed [SQ_BITS-1:0]   sq_u;
      logic signed [SQ_BITS-1:0]   sq_v;
      logic [DIST_BITS-1:0]        d2;
      du = DIFF_BITS'(u) - DIFF_BITS'(s.u) + (drow ? FRAC_ONE : '0);
      dv = DIFF_BITS'(v) - DIFF_BITS'(s.v) + (dcol ? FRAC_ONE : '0);
      sq_u = $signed(du) * $signed(du);
      sq_v = $signed(dv) * $signed(dv);
      d2 = {1'b0, sq_u} + {1'b0, sq_v};
      return s.valid && (d2 < DIST_ONE);
   endfunction

endpackage

`default_nettype wire

// ----- src/jgpds_line_buf.sv -----
// Previous-row sample buffer: one write and one registered read per cycle,
// with write-to-read forwarding. Depends on jgpds_pkg.
`default_nettype none

module jgpds_line_buf
   import jgpds_pkg::*;
(
   input  wire logic                   clock,
   input  wire lb_write_type           wr,
   input  wire logic [LB_IDX_BITS-1:0] rd_idx,
   output      sample_type             rd_data
);

   sample_type mem [COL_LIMIT];
   sample_type rd_data_ff;
   sample_type rd_data_in;

   // Forward a same-cycle write to the same entry
   always_comb begin
      if (wr.en && (wr.idx == rd_idx)) begin
         rd_data_in = wr.data;
      end else begin
         rd_data_in = mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.idx] <= wr.data;
      end
      rd_data_ff <= rd_data_in;
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/jgpds_dist_check.sv -----
// Trial acceptance: border rule plus three neighbor distance checks.
// Depends on jgpds_pkg.
`default_nettype none

module jgpds_dist_check
   import jgpds_pkg::*;
(
   input  wire logic                 border,
   input  wire logic [FRAC_BITS-1:0] u,
   input  wire logic [FRAC_BITS-1:0] v,
   input  wire sample_type           up_sample,
   input  wire sample_type           left_sample,
   input  wire sample_type           diag_sample,
   output      logic                 accept
);

   logic close_up;
   logic close_left;
   logic close_diag;

   // Check the cell above, to the left and diagonal in parallel
   always_comb begin
      close_up   = too_close(up_sample,   u, v, 1'b1, 1'b0);
      close_left = too_close(left_sample, u, v, 1'b0, 1'b1);
      close_diag = too_close(diag_sample, u, v, 1'b1, 1'b1);
      accept     = border || !(close_up || close_left || close_diag);
   end

endmodule

`default_nettype wire

// ----- src/jittered_grid_poisson_disk_sampler.sv -----
// Top level of the jittered-grid Poisson-disk sampler: scan counters,
// configuration registers, request and response stages.
// Depends on jgpds_pkg, jgpds_line_buf and jgpds_dist_check.

// Each request is one trial offset for the current lattice cell; one
// response is produced per decided cell (placed or given up). The block takes
// one request per clock while the response side is not stalled: a request is
// captured in an input register and tested from there, and a decided cell is
// registered in the output register as the response. A trial, rejected
// or not, waits in the input register while an undelivered response holds the
// output, and the request side stalls with it. The previous row is kept in a
// 1024-entry line buffer with one registered read port; its read address
// always follows the next scan column, so the sample above the current cell
// is ready when the trial is decided. The distance checks run in parallel,
// three of them, each squaring two 18-bit differences.
`default_nettype none

module jittered_grid_poisson_disk_sampler
   import jgpds_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_ready,
   input  wire logic [IN_BITS-1:0]       req_rand_u,
   input  wire logic [IN_BITS-1:0]       req_rand_v,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   output      logic                     rsp_placed,
   output      logic [CNT_BITS-1:0]      rsp_cell_row,
   output      logic [CNT_BITS-1:0]      rsp_cell_col,
   output      logic [IN_BITS-1:0]       rsp_pos_u,
   output      logic [IN_BITS-1:0]       rsp_pos_v,
   output      logic [INDEX_BITS-1:0]    rsp_sample_index,
   output      logic                     rsp_last_cell,
   input  wire logic                     csr_write_en,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_write_data
);

   // Configuration
   logic [DIM_BITS-1:0]   num_rows_ff;
   logic [DIM_BITS-1:0]   num_cols_ff;
   logic [TRIES_BITS-1:0] max_tries_ff;

   // Request stage
   logic                 in_valid_ff, in_valid_in;
   logic [FRAC_BITS-1:0] in_u_ff;
   logic [FRAC_BITS-1:0] in_v_ff;

   // Scan state
   logic [CNT_BITS-1:0]   row_ff, row_in;
   logic [CNT_BITS-1:0]   col_ff, col_in;
   logic [TRY_BITS-1:0]   trial_ff, trial_in;
   logic [INDEX_BITS-1:0] count_ff, count_in;
   sample_type            left_ff, left_in;
   sample_type            diag_ff, diag_in;

   // Response stage
   logic                  out_valid_ff, out_valid_in;
   logic                  out_placed_ff;
   logic [CNT_BITS-1:0]   out_row_ff;
   logic [CNT_BITS-1:0]   out_col_ff;
   logic [IN_BITS-1:0]    out_u_ff;
   logic [IN_BITS-1:0]    out_v_ff;
   logic [INDEX_BITS-1:0] out_index_ff;
   logic                  out_last_ff;

   // Decision logic
   logic                    advance;
   logic                    decide;
   logic                    accept;
   logic                    border;
   logic                    last_row;
   logic                    last_col;
   logic [CNT_BITS-1:0]     rows_m1;
   logic [CNT_BITS-1:0]     cols_m1;
   logic [TRY_CMP_BITS-1:0] tries;
   sample_type              up_sample;
   sample_type              stored;
   lb_write_type            lb_wr;

   // Clamp the configuration to its usable range
   always_comb begin
      if (num_rows_ff == '0) begin
         rows_m1 = '0;
      end else if (num_rows_ff > DIM_BITS'(CNT_LIMIT)) begin
         rows_m1 = CNT_BITS'(CNT_LIMIT - 1);
      end else begin
         rows_m1 = CNT_BITS'(num_rows_ff - DIM_BITS'(1));
      end
      if (num_cols_ff == '0) begin
         cols_m1 = '0;
      end else if (num_cols_ff > DIM_BITS'(COL_LIMIT)) begin
         cols_m1 = CNT_BITS'(COL_LIMIT - 1);
      end else begin
         cols_m1 = CNT_BITS'(num_cols_ff - DIM_BITS'(1));
      end
      if (max_tries_ff == '0) begin
         tries = TRY_CMP_BITS'(1);
      end else if (TRY_CMP_BITS'(max_tries_ff) > TRY_CMP_BITS'(TRY_MAX)) begin
         tries = TRY_CMP_BITS'(TRY_MAX);
      end else begin
         tries = TRY_CMP_BITS'(max_tries_ff);
      end
   end

   assign last_row = row_ff >= rows_m1;
   assign last_col = col_ff >= cols_m1;
   assign border   = (row_ff == '0) || (col_ff == '0) || last_row || last_col;

   jgpds_dist_check u_dist_check (
      .border      (border),
      .u           (in_u_ff),
      .v           (in_v_ff),
      .up_sample   (up_sample),
      .left_sample (left_ff),
      .diag_sample (diag_ff),
      .accept      (accept)
   );

   // Handshake: decide a trial only when the response slot is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign decide    = advance &&
                      (accept || ((TRY_CMP_BITS'(trial_ff) + TRY_CMP_BITS'(1)) >= tries));

   always_comb begin
      stored.valid = accept;
      stored.u     = accept ? in_u_ff : '0;
      stored.v     = accept ? in_v_ff : '0;
   end

   // Next scan state
   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      trial_in = trial_ff;
      count_in = count_ff;
      left_in  = left_ff;
      diag_in  = diag_ff;
      if (advance && !decide) begin
         trial_in = trial_ff + TRY_BITS'(1);
      end
      if (decide) begin
         trial_in = '0;
         if (accept) begin
            count_in = count_ff + INDEX_BITS'(1);
         end
         left_in = stored;
         diag_in = up_sample;
         if (!last_col) begin
            col_in = col_ff + CNT_BITS'(1);
         end else begin
            col_in  = '0;
            left_in = '0;
            diag_in = '0;
            if (!last_row) begin
               row_in = row_ff + CNT_BITS'(1);
            end else begin
               row_in   = '0;
               count_in = '0;
            end
         end
      end
   end

   // Store the decided cell for the next row; prefetch the next column
   always_comb begin
      lb_wr.en   = decide;
      lb_wr.idx  = col_ff[LB_IDX_BITS-1:0];
      lb_wr.data = stored;
   end

   jgpds_line_buf u_line_buf (
      .clock   (clock),
      .wr      (lb_wr),
      .rd_idx  (col_in[LB_IDX_BITS-1:0]),
      .rd_data (up_sample)
   );

   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign out_valid_in = decide ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff  <= DIM_BITS'(16);
         num_cols_ff  <= DIM_BITS'(16);
         max_tries_ff <= TRIES_BITS'(30);
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         trial_ff     <= '0;
         count_ff     <= '0;
         left_ff      <= '0;
         diag_ff      <= '0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_NUM_ROWS:  num_rows_ff  <= csr_write_data[DIM_BITS-1:0];
               CSR_NUM_COLS:  num_cols_ff  <= csr_write_data[DIM_BITS-1:0];
               CSR_MAX_TRIES: max_tries_ff <= csr_write_data[TRIES_BITS-1:0];
               default: ;
            endcase
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         trial_ff     <= trial_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         diag_ff      <= diag_in;
      end
   end

   // Payload: capture the request and the decided cell
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_u_ff <= FRAC_BITS'(req_rand_u);
         in_v_ff <= FRAC_BITS'(req_rand_v);
      end
      if (decide) begin
         out_placed_ff <= accept;
         out_row_ff    <= row_ff;
         out_col_ff    <= col_ff;
         out_u_ff      <= accept ? IN_BITS'(in_u_ff) : '0;
         out_v_ff      <= accept ? IN_BITS'(in_v_ff) : '0;
         out_index_ff  <= accept ? count_ff : '0;
         out_last_ff   <= last_row && last_col;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_placed       = out_placed_ff;
   assign rsp_cell_row     = out_row_ff;
   assign rsp_cell_col     = out_col_ff;
   assign rsp_pos_u        = out_u_ff;
   assign rsp_pos_v        = out_v_ff;
   assign rsp_sample_index = out_index_ff;
   assign rsp_last_cell    = out_last_ff;

endmodule

`default_nettype wire
